@@ src/key_triggered_led_fader_top_assert.svh @@
// ----------------------------------------------------------------------------
// key triggered led fader - assertion macros
// shorthand for the clocked, reset-qualified properties of the port checker
// ----------------------------------------------------------------------------
`ifndef KEY_TRIGGERED_LED_FADER_TOP_ASSERT_SVH
`define KEY_TRIGGERED_LED_FADER_TOP_ASSERT_SVH

// same-cycle implication, disabled in reset
`define KTLF_ASSERT_IMP(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("ktlf checker: property failed");

// next-cycle implication, disabled in reset
`define KTLF_ASSERT_NXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("ktlf checker: property failed");

`endif

@@ src/ktlf_pkg.sv @@
// ----------------------------------------------------------------------------
// ktlf_pkg
// shared constants, types and the level scaling function of the led fader
// ----------------------------------------------------------------------------
package ktlf_pkg;

   // channel count and fade runs before a channel stops
   localparam int CHANNELS    = 6;
   localparam int FADE_CYCLES = 4;

   localparam int LEVEL_W   = 8 * CHANNELS;
   localparam int CH_IDX_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int CNT_W     = $clog2(CHANNELS + 1);
   localparam int CSR_IDX_W = 3;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_START   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_END     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_KEYS    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_PRESENT = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_BRIGHT  = 3'd4;

   // register reset values, cut to the channel count
   localparam logic [63:0] START_RESET_ALL = 64'h0000_FF00_C800_FF00;
   localparam logic [63:0] END_RESET_ALL   = 64'h0000_3700_1400_0000;
   localparam logic [7:0]  KEYS_RESET_ALL  = 8'd56;
   localparam logic [7:0]  PRES_RESET_ALL  = 8'd63;

   localparam logic [LEVEL_W-1:0]  START_RESET   = START_RESET_ALL[LEVEL_W-1:0];
   localparam logic [LEVEL_W-1:0]  END_RESET     = END_RESET_ALL[LEVEL_W-1:0];
   localparam logic [CHANNELS-1:0] KEYS_RESET    = KEYS_RESET_ALL[CHANNELS-1:0];
   localparam logic [CHANNELS-1:0] PRESENT_RESET = PRES_RESET_ALL[CHANNELS-1:0];
   localparam logic [7:0]          BRIGHT_RESET  = 8'd200;

   localparam logic [3:0] FADE_TARGET = 4'(FADE_CYCLES);

   typedef logic [7:0]  level_type;
   typedef logic [3:0]  count_type;
   typedef logic [15:0] prod_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_TICK,
      ST_DRAIN,
      ST_DONE
   } ctrl_state_type;

   // controller to datapath
   typedef struct packed {
      logic                capture;
      logic                press;
      logic                step;
      logic                load_rsp;
      logic [CH_IDX_W-1:0] idx;
   } ctrl_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic is_tick;
   } dp_stat_type;

   // 255 - ceil(prod / 255), divide by 255 done by the add-and-shift identity
   function automatic level_type invert_scaled(prod_type prod);
      logic [16:0] x;
      logic [16:0] q;
      x = {1'b0, prod} + 17'd254;
      q = (x + 17'd1 + (x >> 8)) >> 8;
      return 8'd255 - q[7:0];
   endfunction

   // shown level of a value at a brightness
   function automatic level_type scale_level(level_type v, level_type b);
      prod_type p;
      p = 16'(v) * 16'(b);
      return invert_scaled(p);
   endfunction

endpackage

@@ src/ktlf_channels_if.sv @@
// ----------------------------------------------------------------------------
// ktlf channel interfaces
// valid/ready channels for request words and response words
// ----------------------------------------------------------------------------
interface ktlf_req_if;
   import ktlf_pkg::*;

   logic       valid;
   logic       ready;
   logic       req_type;
   logic       pressed_key;
   logic [1:0] keys_held;

   modport source (output valid, req_type, pressed_key, keys_held, input ready);
   modport sink   (input valid, req_type, pressed_key, keys_held, output ready);
endinterface

interface ktlf_rsp_if;
   import ktlf_pkg::*;

   logic                valid;
   logic                ready;
   logic [LEVEL_W-1:0]  led_levels;
   logic [CHANNELS-1:0] active_mask;

   modport source (output valid, led_levels, active_mask, input ready);
   modport sink   (input valid, led_levels, active_mask, output ready);
endinterface

@@ src/ktlf_ctrl.sv @@
// ----------------------------------------------------------------------------
// ktlf_ctrl
// sequencer: takes a word, runs a key press or a channel walk, hands the
// response word to the output register
// ----------------------------------------------------------------------------
module ktlf_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  ktlf_pkg::dp_stat_type  stat,
   output ktlf_pkg::ctrl_cmd_type cmd
);
   import ktlf_pkg::*;

   ctrl_state_type   state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             rsp_free;

   assign rsp_free = !rsp_valid_ff || rsp_ready;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_DISPATCH;
         end
         ST_DISPATCH: begin
            state_in = stat.is_tick ? ST_TICK : ST_DONE;
         end
         ST_TICK: begin
            if (cnt_ff == CNT_W'(CHANNELS - 1)) state_in = ST_DRAIN;
         end
         ST_DRAIN: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (rsp_free) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // outputs
   always_comb begin
      cmd          = '0;
      cmd.idx      = cnt_ff[CH_IDX_W-1:0];
      req_ready    = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid;
         end
         ST_DISPATCH: begin
            cmd.press = !stat.is_tick;
         end
         ST_TICK: begin
            cmd.step = 1'b1;
         end
         ST_DRAIN: begin
            cmd.step = 1'b0;
         end
         ST_DONE: begin
            cmd.load_rsp = rsp_free;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   // channel counter runs only during the walk
   assign cnt_in = (state_ff == ST_TICK) ? cnt_ff + CNT_W'(1) : '0;

   // response valid flag
   always_comb begin
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

@@ src/ktlf_datapath.sv @@
// ----------------------------------------------------------------------------
// ktlf_datapath
// registers, per-channel fade state, one-channel step unit, scaling pipe
// and the response register
// ----------------------------------------------------------------------------
module ktlf_datapath (
   input  logic                             clock,
   input  logic                             reset,
   input  ktlf_pkg::ctrl_cmd_type           cmd,
   output ktlf_pkg::dp_stat_type            stat,
   input  logic                             csr_we,
   input  logic [ktlf_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [ktlf_pkg::LEVEL_W-1:0]     csr_wdata,
   input  logic                             req_type,
   input  logic                             pressed_key,
   input  logic [1:0]                       keys_held,
   output logic [ktlf_pkg::LEVEL_W-1:0]     led_levels,
   output logic [ktlf_pkg::CHANNELS-1:0]    active_mask
);
   import ktlf_pkg::*;

   // configuration
   logic [LEVEL_W-1:0]  start_ff, end_ff;
   logic [CHANNELS-1:0] keys_ff, present_ff;
   level_type           bright_ff;

   // captured request word
   logic       type_ff, key_ff;
   logic [1:0] held_ff;

   // channel state
   level_type           fade_ff   [CHANNELS];
   level_type           fade_in   [CHANNELS];
   count_type           cycle_ff  [CHANNELS];
   count_type           cycle_in  [CHANNELS];
   logic [CHANNELS-1:0] active_ff, active_in;
   level_type           shown_ff  [CHANNELS];
   level_type           shown_in  [CHANNELS];

   // scaling pipe
   logic                upd_ff, upd_in;
   logic [CH_IDX_W-1:0] upd_idx_ff;
   prod_type            prod_ff, prod_in;

   // response register
   logic [LEVEL_W-1:0]  led_ff;
   logic [CHANNELS-1:0] act_ff;

   level_type start_lv [CHANNELS];
   level_type end_lv   [CHANNELS];

   // step unit signals for the selected channel
   level_type s_sel, e_sel, fv, fv_n, vsel;
   count_type cc, cc_n;
   logic      up, hit, dir_up, wrap, hold, enabled;

   // configuration writes, out-of-range indexes ignored
   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff   <= START_RESET;
         end_ff     <= END_RESET;
         keys_ff    <= KEYS_RESET;
         present_ff <= PRESENT_RESET;
         bright_ff  <= BRIGHT_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_START:   start_ff   <= csr_wdata;
            CSR_END:     end_ff     <= csr_wdata;
            CSR_KEYS:    keys_ff    <= csr_wdata[CHANNELS-1:0];
            CSR_PRESENT: present_ff <= csr_wdata[CHANNELS-1:0];
            CSR_BRIGHT:  bright_ff  <= csr_wdata[7:0];
            default:     bright_ff  <= bright_ff;
         endcase
      end
   end

   // request capture
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         type_ff <= req_type;
         key_ff  <= pressed_key;
         held_ff <= keys_held;
      end
   end

   assign stat.is_tick = type_ff;

   // unpack levels
   always_comb begin
      for (int i = 0; i < CHANNELS; i++) begin
         start_lv[i] = start_ff[8*i +: 8];
         end_lv[i]   = end_ff[8*i +: 8];
      end
   end

   // one fade step on the selected channel
   always_comb begin
      s_sel   = start_lv[cmd.idx];
      e_sel   = end_lv[cmd.idx];
      fv      = fade_ff[cmd.idx];
      cc      = cycle_ff[cmd.idx];
      up      = e_sel > s_sel;
      hit     = cc[0] ? (fv == s_sel) : (fv == e_sel);
      dir_up  = cc[0] ? !up : up;
      fv_n    = hit ? fv : (dir_up ? fv + 8'd1 : fv - 8'd1);
      cc_n    = hit ? cc + 4'd1 : cc;
      wrap    = cc_n == FADE_TARGET;
      hold    = held_ff[keys_ff[cmd.idx]];
      enabled = cmd.step && present_ff[cmd.idx] && active_ff[cmd.idx];
      vsel    = wrap ? s_sel : fv_n;
      upd_in  = enabled && !(wrap && hold);
      prod_in = 16'(vsel) * 16'(bright_ff);
   end

   // channel state next values: key press arms in parallel, walk steps one
   always_comb begin
      logic arm;
      for (int i = 0; i < CHANNELS; i++) begin
         fade_in[i]   = fade_ff[i];
         cycle_in[i]  = cycle_ff[i];
         active_in[i] = active_ff[i];
         arm = present_ff[i] && (keys_ff[i] == key_ff) && (start_lv[i] != end_lv[i]);
         if (cmd.press) begin
            if (arm) begin
               active_in[i] = 1'b1;
               cycle_in[i]  = {3'b000, cycle_ff[i][0]};
            end
            if (arm || active_ff[i]) fade_in[i] = start_lv[i];
         end else if (enabled && (cmd.idx == CH_IDX_W'(i))) begin
            fade_in[i]  = fv_n;
            cycle_in[i] = wrap ? 4'd0 : cc_n;
            if (wrap && !hold) active_in[i] = 1'b0;
         end
      end
   end

   // second stage of the scaling pipe writes the shown level
   always_comb begin
      for (int i = 0; i < CHANNELS; i++) begin
         shown_in[i] = shown_ff[i];
      end
      if (upd_ff) shown_in[upd_idx_ff] = invert_scaled(prod_ff);
   end

   // fade values: no reset, every active channel is written on arming
   always_ff @(posedge clock) begin
      for (int i = 0; i < CHANNELS; i++) begin
         fade_ff[i] <= fade_in[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= '0;
         upd_ff    <= 1'b0;
         for (int i = 0; i < CHANNELS; i++) begin
            cycle_ff[i] <= '0;
            shown_ff[i] <= scale_level(START_RESET[8*i +: 8], BRIGHT_RESET);
         end
      end else begin
         active_ff <= active_in;
         upd_ff    <= upd_in;
         for (int i = 0; i < CHANNELS; i++) begin
            cycle_ff[i] <= cycle_in[i];
            shown_ff[i] <= shown_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      prod_ff    <= prod_in;
      upd_idx_ff <= cmd.idx;
   end

   // response register
   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         for (int i = 0; i < CHANNELS; i++) begin
            led_ff[8*i +: 8] <= shown_ff[i];
         end
         act_ff <= active_ff;
      end
   end

   assign led_levels  = led_ff;
   assign active_mask = act_ff;

endmodule

@@ src/key_triggered_led_fader_top.sv @@
// ----------------------------------------------------------------------------
// key_triggered_led_fader_top
// six-channel key triggered led fader with brightness scaling
// ----------------------------------------------------------------------------
//  channel   direction  word contents
//  req_ch    in         req_type, pressed_key, keys_held
//  rsp_ch    out        led_levels, active_mask
//  csr_*     in         write enable, register index, write data
//
//  a key press runs through the dispatch and done states, a tick adds
//  the channel walk, which steps one channel per cycle through
//  the shared step unit, and a drain state for the scaling pipe
//  reset is synchronous; no clearing pass is needed
//  the next word is accepted once the response sits in the output register,
//  so a stalled response side holds at most one finished word
// ----------------------------------------------------------------------------
module key_triggered_led_fader_top (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_we,
   input  logic [ktlf_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [ktlf_pkg::LEVEL_W-1:0]   csr_wdata,
   ktlf_req_if.sink                       req_ch,
   ktlf_rsp_if.source                     rsp_ch
);
   import ktlf_pkg::*;

   ctrl_cmd_type cmd;
   dp_stat_type  stat;

   // sequencer
   ktlf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // datapath
   ktlf_datapath u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .stat        (stat),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .req_type    (req_ch.req_type),
      .pressed_key (req_ch.pressed_key),
      .keys_held   (req_ch.keys_held),
      .led_levels  (rsp_ch.led_levels),
      .active_mask (rsp_ch.active_mask)
   );

endmodule

@@ src/ktlf_checker.sv @@
// ----------------------------------------------------------------------------
// ktlf_checker
// port-level checks of the led fader, bound to the top level
// ----------------------------------------------------------------------------
`include "key_triggered_led_fader_top_assert.svh"

module ktlf_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [ktlf_pkg::LEVEL_W-1:0]  rsp_levels,
   input logic [ktlf_pkg::CHANNELS-1:0] rsp_active
);
   import ktlf_pkg::*;

   // a stalled response stays offered
   `KTLF_ASSERT_NXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid)

   // a stalled response word does not change
   `KTLF_ASSERT_NXT(a_rsp_stable, rsp_valid && !rsp_ready, $stable(rsp_levels) && $stable(rsp_active))

   // one word at a time: ready drops right after an acceptance
   `KTLF_ASSERT_NXT(a_one_in_flight, req_valid && req_ready, !req_ready)

   // a new response only comes out of a busy cycle
   `KTLF_ASSERT_IMP(a_rsp_from_work, $rose(rsp_valid), !$past(req_ready))

endmodule

bind key_triggered_led_fader_top ktlf_checker u_ktlf_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_ch.valid),
   .req_ready  (req_ch.ready),
   .rsp_valid  (rsp_ch.valid),
   .rsp_ready  (rsp_ch.ready),
   .rsp_levels (rsp_ch.led_levels),
   .rsp_active (rsp_ch.active_mask)
);

@@ tb/key_triggered_led_fader_top_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// key_triggered_led_fader_top_test
// self-checking bench for the six-channel key triggered led fader
// key press and tick words in, local fade model predicts each response word
// directed runs first, then random bursts under three idling mixes
// ----------------------------------------------------------------------------
module key_triggered_led_fader_top_test;
   import ktlf_pkg::*;

   // request word kinds and key codes
   localparam logic REQ_PRESS = 1'b0;
   localparam logic REQ_TICK  = 1'b1;
   localparam logic KEY_A     = 1'b0;
   localparam logic KEY_B     = 1'b1;

   localparam int QUIET_LIMIT = 2000;

   typedef struct packed {
      logic [LEVEL_W-1:0]  levels;
      logic [CHANNELS-1:0] mask;
   } fader_word_type;

   logic                 clock = 1'b0;
   logic                 reset;
   logic                 csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [LEVEL_W-1:0]   csr_wdata;

   ktlf_req_if req_bus ();
   ktlf_rsp_if rsp_bus ();

   // model copy of the registers
   logic [LEVEL_W-1:0]  start_cfg;
   logic [LEVEL_W-1:0]  end_cfg;
   logic [CHANNELS-1:0] keys_cfg;
   logic [CHANNELS-1:0] present_cfg;
   level_type           bright_cfg;

   // model copy of the per-channel fade state
   level_type fade_val  [CHANNELS];
   count_type run_count [CHANNELS];
   logic      lit       [CHANNELS];
   level_type shown     [CHANNELS];

   fader_word_type pending_outputs[$];
   int             failures = 0;
   int             quiet_cycles = 0;
   int             tx_idle_pct = 0;
   int             rx_idle_pct = 0;

   key_triggered_led_fader_top dut (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_ch    (req_bus.sink),
      .rsp_ch    (rsp_bus.source)
   );

   always #4 clock = ~clock;

   // inverted, brightness-scaled level: 255 - ceil(v * b / 255)
   function automatic level_type dim_level(level_type v);
      int unsigned p;
      p = 32'(v) * 32'(bright_cfg);
      return level_type'(255 - (p + 254) / 255);
   endfunction

   // one request word through the fade state, giving the response word
   function automatic fader_word_type advance_fader(logic kind, logic key, logic [1:0] held);
      fader_word_type w;
      level_type      s;
      level_type      e;
      if (kind == REQ_PRESS) begin
         for (int i = 0; i < CHANNELS; i++) begin
            s = start_cfg[8*i +: 8];
            e = end_cfg[8*i +: 8];
            if (present_cfg[i] && keys_cfg[i] == key && s != e) begin
               lit[i] = 1'b1;
               run_count[i] = {3'b000, run_count[i][0]};
            end
         end
         // every active channel goes back to its start level
         for (int i = 0; i < CHANNELS; i++)
            if (lit[i])
               fade_val[i] = start_cfg[8*i +: 8];
      end else begin
         for (int i = 0; i < CHANNELS; i++) begin
            if (present_cfg[i] && lit[i]) begin
               s = start_cfg[8*i +: 8];
               e = end_cfg[8*i +: 8];
               // even runs head for the end level, odd runs back to the start
               if (run_count[i][0] == 1'b0) begin
                  if (fade_val[i] == e)
                     run_count[i] = run_count[i] + 4'd1;
                  else
                     fade_val[i] = (e > s) ? fade_val[i] + 8'd1 : fade_val[i] - 8'd1;
               end else begin
                  if (fade_val[i] == s)
                     run_count[i] = run_count[i] + 4'd1;
                  else
                     fade_val[i] = (e > s) ? fade_val[i] - 8'd1 : fade_val[i] + 8'd1;
               end
               if (run_count[i] == FADE_TARGET) begin
                  run_count[i] = '0;
                  // a held key restarts the run and leaves the shown level alone
                  if (!held[keys_cfg[i]]) begin
                     lit[i] = 1'b0;
                     shown[i] = dim_level(s);
                  end
               end else begin
                  shown[i] = dim_level(fade_val[i]);
               end
            end
         end
      end
      for (int i = 0; i < CHANNELS; i++) begin
         w.levels[8*i +: 8] = shown[i];
         w.mask[i] = lit[i];
      end
      return w;
   endfunction

   // prediction on every accepted request word
   always @(posedge clock) begin
      if (!reset && req_bus.valid && req_bus.ready)
         pending_outputs.push_back(advance_fader(req_bus.req_type, req_bus.pressed_key,
                                                 req_bus.keys_held));
   end

   // response checking against the oldest prediction
   always @(posedge clock) begin : check_words
      fader_word_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_outputs.size() == 0) begin
            $error("response word with none expected");
            failures++;
         end else begin
            want = pending_outputs.pop_front();
            if (rsp_bus.led_levels !== want.levels) begin
               $error("led_levels: expected %h, got %h", want.levels, rsp_bus.led_levels);
               failures++;
            end
            if (rsp_bus.active_mask !== want.mask) begin
               $error("active_mask: expected %b, got %b", want.mask, rsp_bus.active_mask);
               failures++;
            end
         end
      end
   end

   // response side stalls
   always @(posedge clock) begin
      rsp_bus.ready <= !reset && ($urandom_range(99) >= rx_idle_pct);
   end

   // watchdog on cycles with no word moving on either channel
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   // send one request word, valid stays high for a following word
   task automatic send_word(input logic kind, input logic key, input logic [1:0] held);
      if ($urandom_range(99) < tx_idle_pct) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_bus.valid       <= 1'b1;
      req_bus.req_type    <= kind;
      req_bus.pressed_key <= key;
      req_bus.keys_held   <= held;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
   endtask

   // stop sending and wait for every predicted word to come back
   task automatic wait_drained();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (pending_outputs.size() != 0) @(posedge clock);
   endtask

   // register write while idle, mirrored into the model
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [LEVEL_W-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_START:   start_cfg = data;
         CSR_END:     end_cfg = data;
         CSR_KEYS:    keys_cfg = data[CHANNELS-1:0];
         CSR_PRESENT: present_cfg = data[CHANNELS-1:0];
         CSR_BRIGHT:  bright_cfg = data[7:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   // reset levels, arming from each key under the reset registers
   task automatic test_reset_levels();
      send_word(REQ_TICK, KEY_B, 2'b00);
      send_word(REQ_PRESS, KEY_A, 2'b11);
      send_word(REQ_PRESS, KEY_B, 2'b00);
   endtask

   // one-step and two-step fades up and down, equal levels, an absent channel
   task automatic test_short_fades();
      wait_drained();
      write_reg(CSR_START, 48'h40_7F_80_10_FF_00);
      write_reg(CSR_END, 48'h41_7F_7E_12_FE_01);
      write_reg(CSR_KEYS, LEVEL_W'(6'b101010));
      write_reg(CSR_PRESENT, LEVEL_W'(6'b011111));
      write_reg(CSR_BRIGHT, LEVEL_W'(8'hFF));
      send_word(REQ_PRESS, KEY_A, 2'b10);
      send_word(REQ_PRESS, KEY_B, 2'b01);
      // held keys walk through every pattern, so runs both stop and restart
      for (int i = 0; i < 10; i++)
         send_word(REQ_TICK, 1'(i), 2'(i >> 1));
   endtask

   // levels, keys, presence and brightness rewritten while channels fade
   task automatic test_level_changes();
      wait_drained();
      write_reg(CSR_START, '0);
      write_reg(CSR_END, 48'hFF_FF_FF_FF_FF_00);
      write_reg(CSR_KEYS, '0);
      write_reg(CSR_PRESENT, LEVEL_W'(6'b111101));
      write_reg(CSR_BRIGHT, '0);
      // indexes past the last register are ignored
      for (int i = int'(CSR_BRIGHT) + 1; i < (1 << CSR_IDX_W); i++)
         write_reg(CSR_IDX_W'(i), '1);
      for (int i = 0; i < 3; i++)
         send_word(REQ_TICK, KEY_A, 2'b11);
      wait_drained();
      write_reg(CSR_PRESENT, '1);
      write_reg(CSR_KEYS, LEVEL_W'(6'b111111));
      send_word(REQ_TICK, KEY_B, 2'b11);
   endtask

   // random bursts: mostly a press then ticks, some stray presses and key noise
   task automatic test_random_traffic(input int word_budget);
      int                 sent;
      int                 burst;
      logic [1:0]         hold;
      logic [LEVEL_W-1:0] starts;
      logic [LEVEL_W-1:0] ends;
      level_type          s;
      level_type          e;
      sent = 0;
      while (sent < word_budget) begin
         wait_drained();
         if ($urandom_range(2) != 0) begin
            // mostly short fades so that runs complete within a burst
            for (int i = 0; i < CHANNELS; i++) begin
               s = 8'($urandom);
               case ($urandom_range(7))
                  0: e = s;
                  1: e = 8'($urandom);
                  default: e = $urandom_range(1) ? s + 8'($urandom_range(1, 3))
                                                 : s - 8'($urandom_range(1, 3));
               endcase
               starts[8*i +: 8] = s;
               ends[8*i +: 8]   = e;
            end
            if ($urandom_range(15) == 0) begin
               starts = '0;
               ends   = '1;
            end
            if ($urandom_range(1) != 0) write_reg(CSR_START, starts);
            if ($urandom_range(1) != 0) write_reg(CSR_END, ends);
            if ($urandom_range(1) != 0)
               write_reg(CSR_KEYS, LEVEL_W'({$urandom, $urandom}));
            if ($urandom_range(1) != 0)
               write_reg(CSR_PRESENT, ($urandom_range(3) == 0) ?
                         LEVEL_W'({$urandom, $urandom}) : '1);
            if ($urandom_range(1) != 0) begin
               case ($urandom_range(3))
                  0: write_reg(CSR_BRIGHT, '0);
                  1: write_reg(CSR_BRIGHT, LEVEL_W'(8'hFF));
                  default: write_reg(CSR_BRIGHT, LEVEL_W'({$urandom, $urandom}));
               endcase
            end
            if ($urandom_range(7) == 0)
               write_reg(CSR_IDX_W'($urandom_range(int'(CSR_BRIGHT) + 1,
                                                   (1 << CSR_IDX_W) - 1)),
                         LEVEL_W'({$urandom, $urandom}));
         end
         burst = $urandom_range(16, 80);
         hold  = 2'($urandom);
         if ($urandom_range(7) != 0) begin
            send_word(REQ_PRESS, 1'($urandom), 2'($urandom));
            sent++;
         end
         repeat (burst) begin
            if ($urandom_range(15) == 0)
               send_word(REQ_PRESS, 1'($urandom), 2'($urandom));
            else
               send_word(REQ_TICK, 1'($urandom),
                         ($urandom_range(7) == 0) ? 2'($urandom) : hold);
            sent++;
         end
      end
   endtask

   initial begin
      reset               <= 1'b1;
      csr_we              <= 1'b0;
      csr_index           <= '0;
      csr_wdata           <= '0;
      req_bus.valid       <= 1'b0;
      req_bus.req_type    <= REQ_PRESS;
      req_bus.pressed_key <= KEY_A;
      req_bus.keys_held   <= 2'b00;

      // model state after reset
      start_cfg   = START_RESET;
      end_cfg     = END_RESET;
      keys_cfg    = KEYS_RESET;
      present_cfg = PRESENT_RESET;
      bright_cfg  = BRIGHT_RESET;
      for (int i = 0; i < CHANNELS; i++) begin
         fade_val[i]  = '0;
         run_count[i] = '0;
         lit[i]       = 1'b0;
         shown[i]     = dim_level(start_cfg[8*i +: 8]);
      end

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      tx_idle_pct = 11;
      rx_idle_pct = 60;
      test_reset_levels();
      test_short_fades();
      test_level_changes();
      test_random_traffic(560);

      tx_idle_pct = 60;
      rx_idle_pct = 11;
      test_random_traffic(560);

      tx_idle_pct = 0;
      rx_idle_pct = 0;
      test_random_traffic(560);

      wait_drained();
      repeat (CHANNELS + 8) @(posedge clock);
      if (failures == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
